// ===== rtl/core/gstr_pkg.sv =====
// Shared types, constants and helpers for the Gardner symbol timing recovery block.
`timescale 1ns / 1ps
`default_nettype none

package gstr_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP_SIZE   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LOOP_GAIN   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ERROR_LIMIT = 2'd2;

    // Register width and reset values
    localparam int unsigned CFG_WIDTH = 24;
    localparam logic [CFG_WIDTH-1:0] STEP_SIZE_RESET   = 24'd188000;
    localparam logic [CFG_WIDTH-1:0] LOOP_GAIN_RESET   = 24'd65536;
    localparam logic [CFG_WIDTH-1:0] ERROR_LIMIT_RESET = 24'd32768;

    // Timestamp tag and distance widths
    localparam int unsigned TIME_WIDTH = 32;
    localparam int unsigned DIST_WIDTH = 32;
    localparam int unsigned DIST_EXT_WIDTH = DIST_WIDTH + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ROUND,
        ST_UPDATE
    } gstr_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul_diff;
        logic mul_lo;
        logic mul_hi;
        logic round;
        logic update;
    } gstr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sym_hit;
        logic out_stall;
    } gstr_stat_t;

    // Saturate an extended distance to the signed distance range
    function automatic logic signed [DIST_WIDTH-1:0] sat_dist(
        input logic signed [DIST_EXT_WIDTH-1:0] v
    );
        logic signed [DIST_EXT_WIDTH-1:0] max_v;
        logic signed [DIST_EXT_WIDTH-1:0] min_v;
        max_v = {3'b000, {(DIST_WIDTH-1){1'b1}}};
        min_v = {3'b111, {(DIST_WIDTH-1){1'b0}}};
        if (v > max_v) begin
            return max_v[DIST_WIDTH-1:0];
        end
        if (v < min_v) begin
            return min_v[DIST_WIDTH-1:0];
        end
        return v[DIST_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gstr_sample_if.sv =====
// Input channel interface: one sample and its timestamp tag per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface gstr_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [31:0]                    sample_time;

    modport source (output valid, output sample, output sample_time, input ready);
    modport sink   (input valid, input sample, input sample_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gstr_symbol_if.sv =====
// Output channel interface: one symbol and its timestamp tag per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface gstr_symbol_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] symbol;
    logic [31:0]                    symbol_time;

    modport source (output valid, output symbol, output symbol_time, input ready);
    modport sink   (input valid, input symbol, input symbol_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gstr_ctrl.sv =====
// Controller state machine that sequences the timing error computation.
`timescale 1ns / 1ps
`default_nettype none

module gstr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire gstr_pkg::gstr_stat_t stat,
    output gstr_pkg::gstr_cmd_t     cmd
);
    import gstr_pkg::*;

    gstr_state_t state_reg;
    gstr_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the error sequence on a symbol sample
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && stat.sym_hit)
                begin
                    state_next = ST_MUL_DIFF;
                end
            end
            ST_MUL_DIFF: state_next = ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_ROUND;
            ST_ROUND:    state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (!stat.out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Drive commands
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL_DIFF: cmd.mul_diff = 1'b1;
            ST_MUL_LO:   cmd.mul_lo   = 1'b1;
            ST_MUL_HI:   cmd.mul_hi   = 1'b1;
            ST_ROUND:    cmd.round    = 1'b1;
            ST_UPDATE:   cmd.update   = !stat.out_stall;
            default:     cmd          = '0;
        endcase
    end

    // A symbol sequence starts only from an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_DIFF) |-> ($past(cmd.load) && $past(stat.sym_hit)))
        else $error("error sequence started without an accepted symbol sample");

    // Rounding follows the high partial product
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> ($past(state_reg) == ST_MUL_HI))
        else $error("rounding entered out of sequence");

endmodule

`default_nettype wire

// ===== rtl/core/gstr_dp.sv =====
// Datapath: configuration, distances, Gardner error arithmetic and output register.
`timescale 1ns / 1ps
`default_nettype none

module gstr_dp #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [gstr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [gstr_pkg::CFG_WIDTH-1:0]         cfg_data,
    input  wire logic signed [SAMPLE_WIDTH-1:0]         sample,
    input  wire logic [gstr_pkg::TIME_WIDTH-1:0]        sample_time,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]              symbol,
    output logic [gstr_pkg::TIME_WIDTH-1:0]             symbol_time,
    input  wire gstr_pkg::gstr_cmd_t                    cmd,
    output gstr_pkg::gstr_stat_t                        stat
);
    import gstr_pkg::*;

    localparam int PROD_WIDTH = 2 * SAMPLE_WIDTH + 1;
    localparam int MAG_WIDTH  = 2 * SAMPLE_WIDTH;
    localparam int PP_WIDTH   = CFG_WIDTH + SAMPLE_WIDTH;
    localparam int SUM_WIDTH  = CFG_WIDTH + 2 * SAMPLE_WIDTH + 1;
    localparam int SHIFT      = 2 * (SAMPLE_WIDTH - 1);
    localparam int RES_WIDTH  = SUM_WIDTH - SHIFT;
    localparam logic signed [DIST_WIDTH-1:0] HALF_DIST =
        DIST_WIDTH'(1) << (FRACTION_BITS - 1);
    localparam logic signed [DIST_EXT_WIDTH-1:0] ONE_DIST =
        DIST_EXT_WIDTH'(1) << FRACTION_BITS;
    localparam logic [SUM_WIDTH-1:0] ROUND_HALF = SUM_WIDTH'(1) << (SHIFT - 1);

    // Configuration registers
    logic [CFG_WIDTH-1:0] step_size_reg;
    logic [CFG_WIDTH-1:0] loop_gain_reg;
    logic [CFG_WIDTH-1:0] error_limit_reg;

    // Loop state
    logic signed [DIST_WIDTH-1:0]   next_dist_reg;
    logic signed [DIST_WIDTH-1:0]   next_dist_next;
    logic signed [DIST_WIDTH-1:0]   mid_dist_reg;
    logic signed [DIST_WIDTH-1:0]   mid_dist_next;
    logic signed [SAMPLE_WIDTH-1:0] prev_symbol_reg;
    logic signed [SAMPLE_WIDTH-1:0] mid_sample_reg;
    logic                           mid_pending_reg;
    logic                           mid_capture;

    // Working registers
    logic signed [SAMPLE_WIDTH-1:0] sample_hold_reg;
    logic [TIME_WIDTH-1:0]          time_hold_reg;
    logic signed [PROD_WIDTH-1:0]   prod_reg;
    logic signed [PROD_WIDTH-1:0]   prod_next;
    logic signed [SAMPLE_WIDTH:0]   diff;
    logic [PROD_WIDTH-1:0]          mag_full;
    logic [MAG_WIDTH-1:0]           mag;
    logic [SAMPLE_WIDTH-1:0]        mag_hi_reg;
    logic                           err_neg_reg;
    logic [PP_WIDTH-1:0]            pp_lo_reg;
    logic [PP_WIDTH-1:0]            pp_lo_next;
    logic [PP_WIDTH-1:0]            pp_hi_reg;
    logic [PP_WIDTH-1:0]            pp_hi_next;
    logic [SUM_WIDTH-1:0]           sum;
    logic [RES_WIDTH-1:0]           res;
    logic [CFG_WIDTH-1:0]           err_mag_reg;
    logic [CFG_WIDTH-1:0]           err_mag_next;

    // Update arithmetic
    logic signed [DIST_EXT_WIDTH-1:0] err_ext;
    logic signed [DIST_EXT_WIDTH-1:0] base;
    logic signed [DIST_WIDTH-1:0]     next_sat;
    logic signed [DIST_WIDTH-1:0]     mid_sat;

    // Output register
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] symbol_reg;
    logic [TIME_WIDTH-1:0]          symbol_time_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg   <= STEP_SIZE_RESET;
            loop_gain_reg   <= LOOP_GAIN_RESET;
            error_limit_reg <= ERROR_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_SIZE:   step_size_reg   <= cfg_data;
                CFG_LOOP_GAIN:   loop_gain_reg   <= cfg_data;
                CFG_ERROR_LIMIT: error_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Flag symbol and mid instants on the current sample
    assign stat.sym_hit   = next_dist_reg < HALF_DIST;
    assign stat.out_stall = out_valid_reg && !out_ready;
    assign mid_capture    = mid_pending_reg && (mid_dist_reg < HALF_DIST);

    // Form the Gardner product
    assign diff      = {prev_symbol_reg[SAMPLE_WIDTH-1], prev_symbol_reg};
    assign prod_next = ($signed({sample_hold_reg[SAMPLE_WIDTH-1], sample_hold_reg}) - diff)
                       * mid_sample_reg;

    // Split the magnitude into two partial products with the gain
    assign mag_full   = prod_reg[PROD_WIDTH-1] ? PROD_WIDTH'(-prod_reg) : prod_reg;
    assign mag        = mag_full[MAG_WIDTH-1:0];
    assign pp_lo_next = loop_gain_reg * mag[SAMPLE_WIDTH-1:0];
    assign pp_hi_next = loop_gain_reg * mag_hi_reg;

    // Round half away from zero and clamp
    assign sum = SUM_WIDTH'(pp_lo_reg) + (SUM_WIDTH'(pp_hi_reg) << SAMPLE_WIDTH) + ROUND_HALF;
    assign res = sum[SUM_WIDTH-1:SHIFT];
    assign err_mag_next = (res > RES_WIDTH'(error_limit_reg)) ? error_limit_reg
                                                               : res[CFG_WIDTH-1:0];

    // New distances after a symbol
    assign err_ext  = err_neg_reg ? -DIST_EXT_WIDTH'(err_mag_reg)
                                  : DIST_EXT_WIDTH'(err_mag_reg);
    assign base     = DIST_EXT_WIDTH'(next_dist_reg) - err_ext;
    assign next_sat = sat_dist(base + DIST_EXT_WIDTH'(step_size_reg));
    assign mid_sat  = sat_dist(base + DIST_EXT_WIDTH'(step_size_reg[CFG_WIDTH-1:1]));

    // Select distance updates: drop one sample either way
    always_comb
    begin
        next_dist_next = next_dist_reg;
        mid_dist_next  = mid_dist_reg;
        if (cmd.load && !stat.sym_hit)
        begin
            next_dist_next = sat_dist(DIST_EXT_WIDTH'(next_dist_reg) - ONE_DIST);
            mid_dist_next  = sat_dist(DIST_EXT_WIDTH'(mid_dist_reg) - ONE_DIST);
        end
        else if (cmd.update)
        begin
            next_dist_next = sat_dist(DIST_EXT_WIDTH'(next_sat) - ONE_DIST);
            mid_dist_next  = sat_dist(DIST_EXT_WIDTH'(mid_sat) - ONE_DIST);
        end
    end

    // Hold loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_dist_reg   <= '0;
            mid_dist_reg    <= '0;
            prev_symbol_reg <= '0;
            mid_sample_reg  <= '0;
            mid_pending_reg <= 1'b1;
        end
        else
        begin
            next_dist_reg <= next_dist_next;
            mid_dist_reg  <= mid_dist_next;
            if (cmd.load && mid_capture)
            begin
                mid_sample_reg  <= sample;
                mid_pending_reg <= 1'b0;
            end
            if (cmd.update)
            begin
                prev_symbol_reg <= sample_hold_reg;
                mid_pending_reg <= 1'b1;
            end
        end
    end

    // Advance the arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_hold_reg <= sample;
            time_hold_reg   <= sample_time;
        end
        if (cmd.mul_diff)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.mul_lo)
        begin
            pp_lo_reg   <= pp_lo_next;
            mag_hi_reg  <= mag[MAG_WIDTH-1:SAMPLE_WIDTH];
            err_neg_reg <= prod_reg[PROD_WIDTH-1];
        end
        if (cmd.mul_hi)
        begin
            pp_hi_reg <= pp_hi_next;
        end
        if (cmd.round)
        begin
            err_mag_reg <= err_mag_next;
        end
    end

    // Hold the output transaction until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            symbol_reg      <= sample_hold_reg;
            symbol_time_reg <= time_hold_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign symbol      = symbol_reg;
    assign symbol_time = symbol_time_reg;

    // Never overwrite a waiting output transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !(out_valid_reg && !out_ready))
        else $error("output transaction overwritten");

    // A symbol re-arms the mid capture and presents a result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> (out_valid_reg && mid_pending_reg))
        else $error("symbol update incomplete");

    // The clamped error never exceeds the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round |=> (err_mag_reg <= $past(error_limit_reg)))
        else $error("timing error exceeds limit");

endmodule

`default_nettype wire

// ===== rtl/core/gardner_symbol_timing_recovery_top.sv =====
// Top level of the Gardner symbol timing recovery block.
//
//  Channel  Dir  Handshake          Payload
//  in_ch    in   valid/ready        sample, sample_time
//  out_ch   out  valid/ready        symbol, symbol_time
//  cfg      in   cfg_we             cfg_index, cfg_data
//
//  A sample that is not nearest a symbol instant is taken while the controller stays idle.
//  A symbol sample steps through accept, product, two gain partial products,
//  round and clamp, and distance update.
//  The update cycle waits while the output register still holds a transaction.
//  Reset clears the distances, previous symbol and mid sample and loads
//  register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module gardner_symbol_timing_recovery_top #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    gstr_sample_if.sink                                 in_ch,
    gstr_symbol_if.source                               out_ch,
    input  wire logic                                   cfg_we,
    input  wire logic [gstr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [gstr_pkg::CFG_WIDTH-1:0]         cfg_data
);
    import gstr_pkg::*;

    gstr_cmd_t cmd;
    gstr_stat_t stat;
    logic in_ready;
    logic signed [SAMPLE_WIDTH-1:0] in_sample;
    logic signed [SAMPLE_WIDTH-1:0] out_symbol;

    assign in_sample     = in_ch.sample;
    assign in_ch.ready   = in_ready;
    assign out_ch.symbol = out_symbol;

    gstr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gstr_dp #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (in_sample),
        .sample_time (in_ch.sample_time),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .symbol      (out_symbol),
        .symbol_time (out_ch.symbol_time),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the Gardner symbol timing recovery block.
`timescale 1ns / 1ps

module testbench;
    import gstr_pkg::*;

    localparam int SAMPLE_WIDTH     = 16;
    localparam int FRACTION_BITS    = 16;
    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 4;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int PHASES           = 8;
    localparam int HOLD_PHASE       = 2;
    localparam int PROD_SHIFT       = 2 * (SAMPLE_WIDTH - 1);
    localparam longint HALF_SAMPLE  = longint'(1) << (FRACTION_BITS - 1);
    localparam longint ONE_SAMPLE   = longint'(1) << FRACTION_BITS;
    localparam longint DIST_CEIL    = 64'sh0000_0000_7FFF_FFFF;
    localparam longint DIST_FLOOR   = -64'sh0000_0000_8000_0000;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [TIME_WIDTH-1:0]          stamp_t;
    typedef logic signed [DIST_WIDTH-1:0]   dist_t;
    typedef logic [CFG_WIDTH-1:0]           reg_t;
    typedef logic [CFG_INDEX_WIDTH-1:0]     reg_index_t;

    typedef struct packed {
        sample_t symbol;
        stamp_t  symbol_time;
    } symbol_t;

    typedef enum bit {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        reg_index_t index;
        reg_t       value;
        sample_t    smp;
        stamp_t     stamp;
        bit         typed;
        symbol_t    want;
    } directed_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    reg_index_t cfg_index;
    reg_t       cfg_data;

    gstr_sample_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) sample_ch ();
    gstr_symbol_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) symbol_ch ();

    gardner_symbol_timing_recovery_top #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (sample_ch),
        .out_ch    (symbol_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Timing tracker copy: distances, last symbol, captured mid sample
    dist_t   sym_dist    = '0;
    dist_t   mid_dist    = '0;
    sample_t last_symbol = '0;
    sample_t held_mid    = '0;
    bit      mid_armed   = 1'b1;
    reg_t    step_reg    = STEP_SIZE_RESET;
    reg_t    gain_reg    = LOOP_GAIN_RESET;
    reg_t    limit_reg   = ERROR_LIMIT_RESET;

    symbol_t expected_symbols[$];
    int      mismatches        = 0;
    bit      source_idling     = 1'b1;
    bit      sink_idling       = 1'b1;
    int      long_holds_asked  = 0;
    int      long_holds_done   = 0;

    // Waveform generator state
    int      wave_level  = 0;
    int      wave_left   = 0;
    int      wave_period = 3;
    stamp_t  stamp_count = '0;

    directed_row_t directed_rows[$];

    function automatic dist_t clamp_distance(input longint v);
        if (v > DIST_CEIL) begin
            return dist_t'(DIST_CEIL);
        end
        if (v < DIST_FLOOR) begin
            return dist_t'(DIST_FLOOR);
        end
        return dist_t'(v);
    endfunction

    // Gain times (current - previous) times mid, rounded half away from zero, clamped
    function automatic longint gardner_error(input sample_t cur, input sample_t prev,
                                             input sample_t mid);
        longint          product;
        longint unsigned magnitude;
        longint unsigned scaled;
        product   = (longint'(cur) - longint'(prev)) * longint'(mid);
        magnitude = (product < 0) ? -product : product;
        scaled    = (magnitude * gain_reg + (64'd1 << (PROD_SHIFT - 1))) >> PROD_SHIFT;
        if (scaled > limit_reg) begin
            scaled = limit_reg;
        end
        return (product < 0) ? -longint'(scaled) : longint'(scaled);
    endfunction

    // Advance the tracker by one sample; report the symbol it emits, if any
    task automatic track_sample(input sample_t smp, input stamp_t stamp,
                                output bit hit, output symbol_t sym);
        longint err;
        longint base;
        hit = 1'b0;
        sym = '0;
        if (mid_armed && mid_dist < HALF_SAMPLE) begin
            held_mid  = smp;
            mid_armed = 1'b0;
        end
        if (sym_dist < HALF_SAMPLE) begin
            err             = gardner_error(smp, last_symbol, held_mid);
            base            = longint'(sym_dist) - err;
            mid_dist        = clamp_distance(base + longint'(step_reg >> 1));
            sym_dist        = clamp_distance(base + longint'(step_reg));
            last_symbol     = smp;
            mid_armed       = 1'b1;
            hit             = 1'b1;
            sym.symbol      = smp;
            sym.symbol_time = stamp;
        end
        sym_dist = clamp_distance(longint'(sym_dist) - ONE_SAMPLE);
        mid_dist = clamp_distance(longint'(mid_dist) - ONE_SAMPLE);
    endtask

    function automatic directed_row_t sample_row(input sample_t smp, input stamp_t stamp);
        directed_row_t row;
        row.kind  = ROW_SAMPLE;
        row.index = '0;
        row.value = '0;
        row.smp   = smp;
        row.stamp = stamp;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic directed_row_t write_row(input reg_index_t index, input reg_t value);
        directed_row_t row;
        row       = sample_row('0, '0);
        row.kind  = ROW_WRITE;
        row.index = index;
        row.value = value;
        return row;
    endfunction

    // Write one register and update the tracker's copy
    task automatic write_register(input reg_index_t index, input reg_t value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (index)
            CFG_STEP_SIZE:   step_reg  = value;
            CFG_LOOP_GAIN:   gain_reg  = value;
            CFG_ERROR_LIMIT: limit_reg = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drop valid, drain all pending symbols, let the block go idle
    task automatic settle_block();
        sample_ch.valid <= 1'b0;
        while (expected_symbols.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic pause_source();
        if (source_idling && $urandom_range(0, 5) == 0) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Offer one sample transaction; on acceptance record the expected symbol
    task automatic offer_sample(input sample_t smp, input stamp_t stamp,
                                input bit typed, input symbol_t typed_want);
        bit      hit;
        symbol_t predicted;
        sample_ch.valid       <= 1'b1;
        sample_ch.sample      <= smp;
        sample_ch.sample_time <= stamp;
        do @(posedge clk); while (!sample_ch.ready);
        track_sample(smp, stamp, hit, predicted);
        if (typed) begin
            expected_symbols.push_back(typed_want);
        end else if (hit) begin
            expected_symbols.push_back(predicted);
        end
    endtask

    // Mostly a held-level symbol waveform with noise, sometimes a raw random sample
    task automatic next_stimulus(output sample_t smp, output stamp_t stamp);
        int noise;
        if (wave_left <= 0) begin
            wave_left  = wave_period;
            wave_level = int'($urandom_range(4000, 30000));
            if ($urandom_range(0, 1) == 1) begin
                wave_level = -wave_level;
            end
        end
        wave_left--;
        noise = int'($urandom_range(0, 4000)) - 2000;
        if ($urandom_range(0, 4) == 0) begin
            smp = sample_t'($urandom);
        end else begin
            smp = sample_t'(wave_level + noise);
        end
        stamp_count++;
        if ($urandom_range(0, 15) == 0) begin
            stamp_count = $urandom;
        end
        stamp = stamp_count;
    endtask

    initial begin : stimulus
        directed_row_t row;
        reg_t          phase_step;
        reg_t          phase_gain;
        reg_t          phase_limit;
        int            phase_items;
        sample_t       smp;
        stamp_t        stamp;

        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= '0;
        cfg_data              <= '0;
        sample_ch.valid       <= 1'b0;
        sample_ch.sample      <= '0;
        sample_ch.sample_time <= '0;

        // First sample after reset is both the mid and the symbol sample
        row       = sample_row(16'sh7FFF, 32'hFFFF_FFFF);
        row.typed = 1'b1;
        row.want  = '{symbol: 16'sh7FFF, symbol_time: 32'hFFFF_FFFF};
        directed_rows.push_back(row);
        directed_rows.push_back(sample_row(16'sh8000, 32'h0000_0000));
        directed_rows.push_back(sample_row(16'sh0000, 32'h0000_0001));
        directed_rows.push_back(sample_row(16'shFFFF, 32'h0000_0002));
        directed_rows.push_back(sample_row(16'sh0001, 32'h0000_0003));
        directed_rows.push_back(sample_row(16'sh8000, 32'h8000_0000));
        directed_rows.push_back(sample_row(16'sh7FFF, 32'h7FFF_FFFF));
        directed_rows.push_back(sample_row(16'sh5555, 32'hAAAA_AAAA));
        directed_rows.push_back(sample_row(16'shAAAA, 32'h5555_5555));
        // Two samples per symbol, loop open, no clamp headroom
        directed_rows.push_back(write_row(CFG_STEP_SIZE, 24'd131072));
        directed_rows.push_back(write_row(CFG_LOOP_GAIN, 24'd0));
        directed_rows.push_back(write_row(CFG_ERROR_LIMIT, 24'd0));
        directed_rows.push_back(sample_row(16'sd20000, 32'd10));
        directed_rows.push_back(sample_row(-16'sd20000, 32'd11));
        directed_rows.push_back(sample_row(-16'sd20000, 32'd12));
        directed_rows.push_back(sample_row(16'sd20000, 32'd13));
        // Zero step with full gain and limit: targets fall behind
        directed_rows.push_back(write_row(CFG_STEP_SIZE, 24'd0));
        directed_rows.push_back(write_row(CFG_LOOP_GAIN, 24'hFF_FFFF));
        directed_rows.push_back(write_row(CFG_ERROR_LIMIT, 24'hFF_FFFF));
        directed_rows.push_back(sample_row(16'sh7FFF, 32'd20));
        directed_rows.push_back(sample_row(16'sh8000, 32'd21));
        directed_rows.push_back(sample_row(16'sh7FFF, 32'd22));
        directed_rows.push_back(sample_row(16'sh8000, 32'd23));
        // Odd step: the half step truncates
        directed_rows.push_back(write_row(CFG_STEP_SIZE, 24'd65537));
        directed_rows.push_back(write_row(CFG_LOOP_GAIN, LOOP_GAIN_RESET));
        directed_rows.push_back(write_row(CFG_ERROR_LIMIT, 24'h0F_FFFF));
        directed_rows.push_back(sample_row(16'sd100, 32'd30));
        directed_rows.push_back(sample_row(-16'sd100, 32'd31));
        directed_rows.push_back(sample_row(16'sd12345, 32'd32));
        // Largest step
        directed_rows.push_back(write_row(CFG_STEP_SIZE, 24'hFF_FFFF));
        directed_rows.push_back(write_row(CFG_ERROR_LIMIT, 24'd65535));
        directed_rows.push_back(sample_row(16'shFFFF, 32'd40));
        directed_rows.push_back(sample_row(16'sh0001, 32'd41));
        directed_rows.push_back(sample_row(16'sh7FFF, 32'hFFFF_FFFE));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                settle_block();
                write_register(directed_rows[i].index, directed_rows[i].value);
            end else begin
                pause_source();
                offer_sample(directed_rows[i].smp, directed_rows[i].stamp,
                             directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases, one register setting each
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    phase_step  = STEP_SIZE_RESET;
                    phase_gain  = LOOP_GAIN_RESET;
                    phase_limit = ERROR_LIMIT_RESET;
                    phase_items = 120;
                end
                1: begin
                    phase_step  = 24'd131072;
                    phase_gain  = 24'd0;
                    phase_limit = 24'd0;
                    phase_items = 80;
                end
                HOLD_PHASE: begin
                    phase_step  = 24'd0;
                    phase_gain  = LOOP_GAIN_RESET;
                    phase_limit = ERROR_LIMIT_RESET;
                    phase_items = 50;
                end
                3: begin
                    phase_step  = 24'd65536;
                    phase_gain  = 24'hFF_FFFF;
                    phase_limit = 24'hFF_FFFF;
                    phase_items = 60;
                end
                4: begin
                    phase_step  = 24'd300001;
                    phase_gain  = 24'd200000;
                    phase_limit = 24'd65536;
                    phase_items = 120;
                end
                5: begin
                    phase_step  = 24'hFF_FFFF;
                    phase_gain  = 24'hFF_FFFF;
                    phase_limit = 24'd0;
                    phase_items = 200;
                end
                6: begin
                    phase_step  = 24'd1048576;
                    phase_gain  = reg_t'($urandom);
                    phase_limit = reg_t'($urandom);
                    phase_items = 100;
                end
                default: begin
                    phase_step  = reg_t'($urandom_range(131072, 600000));
                    phase_gain  = reg_t'($urandom_range(0, 1 << 20));
                    phase_limit = reg_t'($urandom_range(0, 1 << 17));
                    phase_items = 120;
                end
            endcase

            settle_block();
            write_register(CFG_STEP_SIZE, phase_step);
            write_register(CFG_LOOP_GAIN, phase_gain);
            write_register(CFG_ERROR_LIMIT, phase_limit);

            wave_period = int'(phase_step >> FRACTION_BITS);
            if (wave_period < 1) begin
                wave_period = 1;
            end
            source_idling = ($urandom_range(0, 3) != 0);
            sink_idling   = ($urandom_range(0, 3) != 0);
            if (p == HOLD_PHASE) begin
                // Keep offering while the output is held off
                source_idling = 1'b0;
                long_holds_asked++;
            end
            if (p == PHASES - 1) begin
                source_idling = 1'b0;
                sink_idling   = 1'b0;
            end

            repeat (phase_items) begin
                pause_source();
                next_stimulus(smp, stamp);
                offer_sample(smp, stamp, 1'b0, '0);
            end
        end

        settle_block();
        if (mismatches == 0) begin
            $display("[gardner_symbol_timing_recovery_top] OK");
        end else begin
            $display("[gardner_symbol_timing_recovery_top] ERROR");
        end
        $finish;
    end

    // Drive output ready: random stall bursts, one long hold on request
    initial begin : symbol_sink
        symbol_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (long_holds_asked != long_holds_done) begin
                long_holds_done++;
                symbol_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end else if (sink_idling && $urandom_range(0, 5) == 0) begin
                symbol_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end else begin
                symbol_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each symbol transaction with the oldest expected symbol
    always @(posedge clk) begin : symbol_check
        symbol_t want;
        if (rst_n && symbol_ch.valid && symbol_ch.ready) begin
            if (expected_symbols.size() == 0) begin
                $error("unexpected symbol %0d, symbol_time 0x%08h",
                       symbol_ch.symbol, symbol_ch.symbol_time);
                mismatches++;
            end else begin
                want = expected_symbols.pop_front();
                if (symbol_ch.symbol !== want.symbol) begin
                    $error("symbol: expected %0d, actual %0d", want.symbol, symbol_ch.symbol);
                    mismatches++;
                end
                if (symbol_ch.symbol_time !== want.symbol_time) begin
                    $error("symbol_time: expected 0x%08h, actual 0x%08h",
                           want.symbol_time, symbol_ch.symbol_time);
                    mismatches++;
                end
            end
        end
    end

    // End the run when no transaction moves for too long
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (symbol_ch.valid && symbol_ch.ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("[gardner_symbol_timing_recovery_top] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/gstr_pkg.sv
rtl/core/gstr_sample_if.sv
rtl/core/gstr_symbol_if.sv
rtl/core/gstr_ctrl.sv
rtl/core/gstr_dp.sv
rtl/core/gardner_symbol_timing_recovery_top.sv
tb/testbench.sv
